### hw/rtl/cqe_pkg.sv
// Shared types and codes for the circular queue engine.
// Used by the front end, the back end and the top level; depends on nothing.
`default_nettype none

package cqe_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_TRAV  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DEQ  = 2'd1,
        BK_TRAV = 2'd2
    } back_state_t;

endpackage

`default_nettype wire

### hw/rtl/cqe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds no reset state.
`default_nettype none

module cqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/cqe_front.sv
// Front end: takes input items, classifies the operation and holds them in a
// two-entry command queue for the back end. Depends on cqe_pkg.
`default_nettype none

module cqe_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    output logic             cmd_valid,
    output cqe_pkg::cmd_t    cmd,
    input  wire logic        cmd_pop
);

    import cqe_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    cmd_t       incoming;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = cmd_pop && cmd_valid;

    // The operation code is classified here; every two-bit pattern is a member.
    assign incoming.op    = op_t'(s_tuser);
    assign incoming.value = s_tdata;

    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cqe_back.sv
// Back end: carries out queued commands against the circular store and
// drives the result register. Depends on cqe_pkg and cqe_ram.
`default_nettype none

module cqe_back #(
    parameter int DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    input  cqe_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    output logic [3:0]       m_tuser,
    output logic             m_tlast
);

    import cqe_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [IDX_W-1:0]         head_reg;
    logic [IDX_W-1:0]         head_next;
    logic [IDX_W-1:0]         tail_reg;
    logic [IDX_W-1:0]         tail_next;
    logic                     empty_reg;
    logic                     empty_next;
    logic [IDX_W-1:0]         trav_reg;
    logic [IDX_W-1:0]         trav_next;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_full_reg;
    logic                     out_empty_reg;
    logic                     out_last_reg;

    logic                     can_load;
    logic                     load;
    status_t                  res_status;
    logic signed [DATA_W-1:0] res_data;
    logic                     res_last;
    logic                     full_now;
    logic                     full_after;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic [DATA_W-1:0]        rd_data;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] n;
        if (i == IDX_W'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = i + 1'b1;
        end
        return n;
    endfunction

    cqe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign can_load   = !out_valid_reg || m_tready;
    assign full_now   = !empty_reg && (next_idx(tail_reg) == head_reg);
    assign full_after = !empty_next && (next_idx(tail_next) == head_next);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        trav_next  = trav_reg;
        cmd_pop    = 1'b0;
        load       = 1'b0;
        res_status = ST_OK;
        res_data   = '0;
        res_last   = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = head_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && can_load)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_ENQ:
                        begin
                            load = 1'b1;
                            if (full_now)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                // An empty queue restarts at slot zero.
                                if (empty_reg)
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                                else
                                begin
                                    tail_next = next_idx(tail_reg);
                                end
                                empty_next = 1'b0;
                                wr_en      = 1'b1;
                                wr_addr    = tail_next;
                            end
                        end
                        OP_DEQ:
                        begin
                            if (empty_reg)
                            begin
                                load       = 1'b1;
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = BK_DEQ;
                            end
                        end
                        OP_TRAV:
                        begin
                            if (empty_reg)
                            begin
                                load       = 1'b1;
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                trav_next  = head_reg;
                                state_next = BK_TRAV;
                            end
                        end
                        OP_QUERY:
                        begin
                            load = 1'b1;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            BK_DEQ:
            begin
                if (can_load)
                begin
                    load     = 1'b1;
                    res_data = rd_data;
                    // Removing the only entry empties the queue and rewinds it.
                    if (head_reg == tail_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        head_next = next_idx(head_reg);
                    end
                    state_next = BK_IDLE;
                end
            end
            BK_TRAV:
            begin
                if (can_load)
                begin
                    load     = 1'b1;
                    res_data = rd_data;
                    res_last = (trav_reg == tail_reg);
                    if (res_last)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        trav_next = next_idx(trav_reg);
                        rd_en     = 1'b1;
                        rd_addr   = next_idx(trav_reg);
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            trav_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            trav_reg  <= trav_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= res_status;
            out_data_reg   <= res_data;
            out_full_reg   <= full_after;
            out_empty_reg  <= empty_next;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_empty_reg, out_full_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### hw/rtl/circular_queue_engine.sv
// Circular queue engine: enqueue, dequeue, traverse and status query on a
// DEPTH-entry queue of signed 32-bit values. Depends on cqe_pkg, cqe_front,
// cqe_back and cqe_ram.
// Each result passes a front-end slot and the result register, a dequeue's
// also the registered store read. While m_tready does not stall, enqueues
// and queries go one a cycle and a traverse gives one result per entry, one a
// cycle; dequeue and traverse hold the back end until done. Reset empties the queue.
`default_nettype none

module circular_queue_engine #(
    parameter int DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value[31:0]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // data[31:0]
    output logic [3:0]       m_tuser,   // status[1:0], is_full[2], is_empty[3]
    output logic             m_tlast    // last result of the item
);

    import cqe_pkg::*;

    // The front end buffers up to two classified items, so the input side keeps
    // moving while the back end is busy with a traverse or a stalled result.
    // The back end owns the queue pointers, the empty flag and the entry store.
    // Each result carries the full and empty flags as they stand after the
    // operation; a traverse holds the state and walks head to tail.

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    cqe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    cqe_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
